// File: sv/bmp_pkg.sv
`timescale 1ns / 1ps
package bmp_pkg;
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned NWidth = 12;
  localparam int unsigned KWidth = 13;
  localparam int unsigned VWidth = 30;
  localparam logic [29:0] Prime = 30'd1000000007;
  localparam logic [29:0] FermatExp = 30'd1000000005;
  // Barrett constant, floor(2^60 / Prime).
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(Prime));

  typedef enum logic [2:0] {
    BUILD_FACT,
    POW_MUL,
    POW_WAIT,
    BUILD_INV,
    BUILD_WAIT,
    READY
  } build_state_t;
endpackage

// File: sv/bmp_mulmod.sv
`timescale 1ns / 1ps
// Pipelined modular multiply, four register stages: the product, a Barrett
// quotient estimate, the remainder (below three times the prime) and two
// compare-subtracts that bring it below the prime.
module bmp_mulmod (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic [29:0] p
);
  import bmp_pkg::*;
  logic [59:0] prod;
  logic [61:0] est;
  logic [31:0] low1;
  logic [31:0] rem;
  logic [31:0] rem_a;
  logic [31:0] rem_b;

  always_comb begin
    rem_a = (rem >= {2'b0, Prime}) ? rem - {2'b0, Prime} : rem;
    rem_b = (rem_a >= {2'b0, Prime}) ? rem_a - {2'b0, Prime} : rem_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {30'b0, a} * {30'b0, b};
      est <= {31'b0, prod[59:29]} * {31'b0, BarrettMu};
      low1 <= prod[31:0];
      // Only the low 32 bits matter since the true remainder fits in them.
      rem <= low1 - ({1'b0, est[61:31]} * {2'b0, Prime});
      p <= rem_b[29:0];
    end
  end
endmodule

// File: sv/bmp_tables.sv
`timescale 1ns / 1ps
// Builds factorial and inverse factorial memories after reset using one
// shared multiplier; then answers three registered reads per cycle while rd_en is high.
module bmp_tables #(
  parameter int unsigned TABLE_DEPTH = bmp_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst,
  output logic        ready,
  input  logic        rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_n,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_k,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_m,
  output logic [29:0] fact_n,
  output logic [29:0] inv_k,
  output logic [29:0] inv_m
);
  import bmp_pkg::*;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] Top = AW'(TABLE_DEPTH - 1);

  logic [29:0] fact_mem [TABLE_DEPTH];
  logic [29:0] inv_mem_a [TABLE_DEPTH];
  logic [29:0] inv_mem_b [TABLE_DEPTH];

  build_state_t state, state_next;
  logic [AW-1:0] idx;
  logic [4:0] wait_cnt;
  logic [29:0] cur;
  logic [29:0] base;
  logic [29:0] acc;
  logic [4:0] bit_pos;
  logic       sq_phase;
  logic [29:0] ma, mb, mp;

  bmp_mulmod u_mul (.clk(clk), .en(1'b1), .a(ma), .b(mb), .p(mp));

  always_comb begin
    state_next = state;
    unique case (state)
      BUILD_FACT: if (wait_cnt == 5'd4 && idx == Top) state_next = POW_MUL;
      POW_MUL:    state_next = POW_WAIT;
      POW_WAIT:   if (wait_cnt == 5'd4 && sq_phase && bit_pos == 5'd0) state_next = BUILD_INV;
                  else if (wait_cnt == 5'd4) state_next = POW_MUL;
      BUILD_INV:  state_next = BUILD_WAIT;
      BUILD_WAIT: if (wait_cnt == 5'd4 && idx == AW'(1)) state_next = READY;
                  else if (wait_cnt == 5'd4) state_next = BUILD_INV;
      READY:      state_next = READY;
      default:    state_next = BUILD_FACT;
    endcase
  end

  always_comb begin
    ma = cur;
    mb = {{(30-AW){1'b0}}, idx};
    unique case (state)
      BUILD_FACT: begin ma = cur; mb = {{(30-AW){1'b0}}, idx}; end
      POW_MUL, POW_WAIT: begin
        ma = sq_phase ? base : acc;
        mb = base;
      end
      BUILD_INV, BUILD_WAIT: begin ma = cur; mb = {{(30-AW){1'b0}}, idx}; end
      default: begin ma = cur; mb = cur; end
    endcase
  end

  assign ready = (state == READY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BUILD_FACT;
      idx <= AW'(1);
      wait_cnt <= '0;
      cur <= 30'd1;
      acc <= 30'd1;
      bit_pos <= 5'd29;
      sq_phase <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BUILD_FACT: begin
          if (wait_cnt == 5'd4) begin
            wait_cnt <= '0;
            cur <= mp;
            if (idx == Top) begin
              base <= mp;
              acc <= 30'd1;
              bit_pos <= 5'd29;
              sq_phase <= 1'b0;
            end else idx <= idx + AW'(1);
          end else wait_cnt <= wait_cnt + 5'd1;
        end
        POW_MUL: wait_cnt <= 5'd1;
        POW_WAIT: begin
          if (wait_cnt == 5'd4) begin
            wait_cnt <= '0;
            if (!sq_phase) begin
              if (FermatExp[29 - bit_pos]) acc <= mp;
              sq_phase <= 1'b1;
            end else begin
              base <= mp;
              sq_phase <= 1'b0;
              if (bit_pos == 5'd0) begin
                cur <= acc;
                idx <= Top;
              end else bit_pos <= bit_pos - 5'd1;
            end
          end else wait_cnt <= wait_cnt + 5'd1;
        end
        BUILD_INV: wait_cnt <= 5'd1;
        BUILD_WAIT: begin
          if (wait_cnt == 5'd4) begin
            wait_cnt <= '0;
            cur <= mp;
            idx <= idx - AW'(1);
          end else wait_cnt <= wait_cnt + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (state == BUILD_FACT && wait_cnt == 5'd0) fact_mem[idx - AW'(1)] <= cur;
    if (state == BUILD_FACT && wait_cnt == 5'd4 && idx == Top) fact_mem[Top] <= mp;
    if (state == BUILD_INV) begin
      inv_mem_a[idx] <= cur;
      inv_mem_b[idx] <= cur;
    end
    if (state == BUILD_WAIT && wait_cnt == 5'd4 && idx == AW'(1)) begin
      inv_mem_a[0] <= mp;
      inv_mem_b[0] <= mp;
    end
    if (rd_en) begin
      fact_n <= fact_mem[rd_n];
      inv_k <= inv_mem_a[rd_k];
      inv_m <= inv_mem_b[rd_m];
    end
  end
endmodule

// File: sv/binomial_mod_prime_top.sv
`timescale 1ns / 1ps
// Binomial coefficient C(n,k) mod 1000000007.
// Input channel s_axis: one word per query, n and k packed in tdata.
// Output channel m_axis: one word per query with the coefficient, in order.
// After reset the block builds its factorial table (one multiply per
// entry), the Fermat inverse of the top factorial (60 multiplies,
// exponent bits taken from the bottom) and the inverse factorial table
// (one multiply per entry); s_axis_tready stays low until all are built.
// Afterwards one query is accepted every cycle while the output is not stalled.
// Each query passes a registered table read and two pipelined four-stage modular multiplies.
// Queries with k negative, k > n or n beyond the table give zero.
// When m_axis_tready is low while m_axis_tvalid is high, the whole pipeline
// holds in place and s_axis_tready falls, so no word is lost or repeated.
module binomial_mod_prime_top #(
  parameter int unsigned TABLE_DEPTH = bmp_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [11:0] total_count, [24:12] chosen_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [29:0] binomial_value
);
  import bmp_pkg::*;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned Lat = 9;

  logic        ready;
  logic        adv;
  logic [Lat-1:0] vld;
  logic [Lat-1:0] ok;
  logic [11:0] n_in;
  logic [12:0] k_in;
  logic        in_ok;
  logic [12:0] diff;
  logic [29:0] fact_n, inv_k, inv_m, p1, p2;
  logic [29:0] inv_k_d [4];

  assign n_in = s_axis_tdata[11:0];
  assign k_in = s_axis_tdata[24:12];
  assign diff = {1'b0, n_in} - k_in;
  assign in_ok = !k_in[12] && (k_in[11:0] <= n_in) &&
                 ({20'b0, n_in} < 32'(TABLE_DEPTH));

  assign adv = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = ready && adv;
  assign m_axis_tvalid = vld[Lat-1];
  assign m_axis_tdata = {2'b0, ok[Lat-1] ? p2 : 30'd0};

  bmp_tables #(.TABLE_DEPTH(TABLE_DEPTH)) u_tables (
    .clk(clk), .rst(rst), .ready(ready), .rd_en(adv),
    .rd_n(AW'(n_in)), .rd_k(AW'(k_in[11:0])), .rd_m(AW'(diff[11:0])),
    .fact_n(fact_n), .inv_k(inv_k), .inv_m(inv_m)
  );

  bmp_mulmod u_m1 (.clk(clk), .en(adv), .a(fact_n), .b(inv_k), .p(p1));
  bmp_mulmod u_m2 (.clk(clk), .en(adv), .a(p1), .b(inv_k_d[3]), .p(p2));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok <= {ok[Lat-2:0], in_ok};
      inv_k_d[0] <= inv_m;
      inv_k_d[1] <= inv_k_d[0];
      inv_k_d[2] <= inv_k_d[1];
      inv_k_d[3] <= inv_k_d[2];
    end
  end
endmodule

// File: tb/sv/tb_binomial_mod_prime_top.sv
`timescale 1ns / 1ps
module tb_binomial_mod_prime_top;
  import bmp_pkg::*;

  localparam int unsigned Depth = TableDepth;
  localparam longint unsigned Modulus = 64'd1000000007;
  localparam int unsigned LatencyCycles = 9;
  // The limit allows for the table build and for every query meeting a full
  // sender gap and a full receiver stall.
  localparam longint unsigned CycleLimit = 64'd2000000;
  localparam int unsigned RandomQueries = 1700;

  // Rows with a value of -1 are checked against the predictor only.
  typedef struct {
    logic [11:0] n;
    logic [12:0] k;
    longint      value;
  } query_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  binomial_mod_prime_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),  // [11:0] total_count, [24:12] chosen_count
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)   // [29:0] binomial_value
  );

  // The testbench keeps its own factorial and inverse factorial tables.
  logic [29:0] fact_mod[Depth];
  logic [29:0] inv_fact_mod[Depth];

  logic [29:0] pending_values[$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned zero_words;
  longint unsigned cycle_count;
  bit          quiet_tail;
  bit          sender_done;
  bit          long_hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
    return ((a % Modulus) * (b % Modulus)) % Modulus;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex);
    longint unsigned acc;
    acc = 1;
    base = base % Modulus;
    while (ex != 0) begin
      if (ex[0]) acc = mul_mod(acc, base);
      base = mul_mod(base, base);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  task automatic build_tables();
    fact_mod[0] = 30'd1;
    for (int i = 1; i < Depth; i++) fact_mod[i] = 30'(mul_mod(fact_mod[i - 1], i));
    inv_fact_mod[Depth - 1] = 30'(pow_mod(fact_mod[Depth - 1], Modulus - 2));
    for (int i = Depth - 1; i > 0; i--) begin
      inv_fact_mod[i - 1] = 30'(mul_mod(inv_fact_mod[i], i));
    end
  endtask

  // C(n,k) mod the prime; zero for negative k, k above n or n past the table.
  function automatic logic [29:0] binomial_mod(logic [11:0] n, logic [12:0] k);
    longint unsigned v;
    if (k[12] || k[11:0] > n || n >= Depth) return 30'd0;
    v = mul_mod(fact_mod[n], inv_fact_mod[k[11:0]]);
    v = mul_mod(v, inv_fact_mod[n - k[11:0]]);
    return 30'(v);
  endfunction

  // Directed queries: the extremes of both fields, negative k, k above n.
  query_row_t directed_rows[20] = '{
    '{12'd0,    13'd0,      1},
    '{12'd4095, 13'd0,      1},
    '{12'd4095, 13'd4095,   1},
    '{12'd4095, 13'd1,      4095},
    '{12'd4095, 13'd4094,   4095},
    '{12'd1,    13'd1,      1},
    '{12'd5,    13'd2,      10},
    '{12'd10,   13'd5,      252},
    '{12'd0,    13'h1FFF,   0},
    '{12'd4095, 13'h1000,   0},
    '{12'd4095, 13'h1FFF,   0},
    '{12'd0,    13'd1,      0},
    '{12'd0,    13'd4095,   0},
    '{12'd100,  13'd101,    0},
    '{12'd4094, 13'd4095,   0},
    '{12'd2048, 13'd1024,   -1},
    '{12'd4095, 13'd2047,   -1},
    '{12'd3000, 13'd1500,   -1},
    '{12'd2730, 13'd1365,   -1},
    '{12'd1365, 13'd682,    -1}
  };

  // Hand one word over at the falling edge and hold it until it is taken.
  task automatic send_query(logic [11:0] n, logic [12:0] k);
    s_axis_tdata  <= {7'd0, k, n};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_values = {pending_values, binomial_mod(n, k)};
    words_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int unsigned gap;
    if (quiet_tail || $urandom_range(3, 0) != 0) return;
    gap = $urandom_range(5, 1);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
    repeat (gap) @(negedge clk);
  endtask

  // Random query shaped to hit the in-range cases mostly, edges and junk sometimes.
  task automatic random_query();
    logic [11:0] n;
    logic [12:0] k;
    int unsigned pick;
    pick = $urandom_range(9, 0);
    n = 12'($urandom);
    if (pick < 6) begin
      k = {1'b0, 12'($urandom_range(n, 0))};
    end else if (pick == 6) begin
      k = (pick[0] || n == 0) ? 13'd0 : {1'b0, n};
      if ($urandom_range(1, 0)) k = {1'b0, n};
    end else if (pick == 7) begin
      k = {1'b1, 12'($urandom)};
    end else if (pick == 8) begin
      k = 13'($urandom);
    end else begin
      n = ($urandom_range(1, 0)) ? 12'd4095 : 12'($urandom_range(15, 0));
      k = {1'b0, 12'($urandom_range(n, 0))};
    end
    send_query(n, k);
  endtask

  // Sender: directed table first, then the random queries.
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst           = 1'b1;
    error_count   = 0;
    words_sent    = 0;
    quiet_tail    = 1'b0;
    sender_done   = 1'b0;
    build_tables();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].value >= 0 &&
          binomial_mod(directed_rows[i].n, directed_rows[i].k) !=
          30'(directed_rows[i].value)) begin
        $display("%0t: table row %0d expected %0d, predictor %0d", $time, i,
                 directed_rows[i].value,
                 binomial_mod(directed_rows[i].n, directed_rows[i].k));
        error_count++;
      end
      send_query(directed_rows[i].n, directed_rows[i].k);
      sender_gap();
    end
    for (int i = 0; i < RandomQueries; i++) begin
      if (i > RandomQueries * 9 / 10) quiet_tail = 1'b1;
      random_query();
      sender_gap();
    end
    s_axis_tvalid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off early on to back up the pipe.
  initial begin
    m_axis_tready = 1'b0;
    long_hold_done = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_sent > 40) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (!quiet_tail && $urandom_range(3, 0) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Each accepted word is matched against the oldest prediction.
  initial begin
    logic [29:0] wanted;
    words_checked = 0;
    zero_words    = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time,
                   m_axis_tdata[29:0]);
          error_count++;
        end else begin
          wanted = pending_values.pop_front();
          if (m_axis_tdata[29:0] !== wanted) begin
            $display("%0t: binomial_value expected %0d, actual %0d", $time, wanted,
                     m_axis_tdata[29:0]);
            error_count++;
          end
          if (wanted == 0) zero_words++;
        end
        words_checked++;
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb_binomial_mod_prime_top NOT OK");
        $finish;
      end
      if (sender_done && pending_values.size() == 0) begin
        repeat (LatencyCycles * 3) @(posedge clk);
        $display("Sent %0d queries and checked %0d words, %0d of them zero results,",
                 words_sent, words_checked, zero_words);
        $display("covering field extremes, negative k, k above n and a long output stall.");
        if (error_count == 0 && pending_values.size() == 0) begin
          $display("tb_binomial_mod_prime_top OK");
        end else begin
          $display("tb_binomial_mod_prime_top NOT OK");
        end
        $finish;
      end
    end
  end
endmodule
